// File: rtl/assert_macros.svh
// Assertion helpers used by the receiver unit.
// Each use checks on the rising edge of clk_i and stays quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_AT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed");

`endif

// File: rtl/asfr_pkg.sv
`default_nettype none

package asfr_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned LenOutW = 6;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgHeaderValue = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNodeAddress = 2'd1;

  // Register reset values
  localparam logic [ByteW-1:0] HeaderReset    = 8'hFF;
  localparam logic [ByteW-1:0] NodeReset      = 8'h00;
  localparam logic [ByteW-1:0] BroadcastAddr  = 8'h00;

  // Default data buffer depth
  localparam int unsigned MaxDataBytesDef = 32;

  // Frame sequencer states
  typedef enum logic [2:0] {
    ST_HEADER,
    ST_ADDRESS,
    ST_LENGTH,
    ST_COMMAND,
    ST_DATA,
    ST_CHECKSUM,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/asfr_ram.sv
`default_nettype none

module asfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/addressed_serial_frame_receiver_unit.sv
// Parsing: one received word per cycle while the input is not stalled, with no wait between words.
// A good checksum puts the command word out in the cycle after it is accepted;
// the N data words then come from the buffer RAM, fetched and moved to the output,
// one a cycle when the output does not stall; the input stalls until the last is moved.
// Reset: asynchronous, active low; parser waits for a header, header 0xFF,
// node address 0; the data buffer is not cleared.
`default_nettype none
`include "assert_macros.svh"

module addressed_serial_frame_receiver_unit #(
  parameter int unsigned MaxDataBytes = asfr_pkg::MaxDataBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Received words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [asfr_pkg::ByteW-1:0]    rx_byte_i,
  // Frame results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               is_command_o,
  output logic      [asfr_pkg::ByteW-1:0]    value_o,
  output logic      [asfr_pkg::LenOutW-1:0]  frame_length_o,
  output logic                               last_o,
  // Configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [asfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [asfr_pkg::ByteW-1:0]    cfg_data_i
);

  localparam int unsigned AddrW = (MaxDataBytes > 1) ? $clog2(MaxDataBytes) : 1;
  localparam int unsigned ByteW = asfr_pkg::ByteW;
  localparam int unsigned IdxW  = asfr_pkg::IdxW;
  localparam logic [ByteW:0] MaxLen = (ByteW + 1)'(MaxDataBytes + 1);
  localparam logic [IdxW:0]  MaxIdx = (IdxW + 1)'(MaxDataBytes);

  asfr_pkg::state_e state_q, state_d;

  logic [ByteW-1:0] header_q, node_q;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;

  logic                        out_valid_q, out_valid_d;
  logic                        out_cmd_q, out_cmd_d;
  logic [ByteW-1:0]            out_val_q, out_val_d;
  logic [asfr_pkg::LenOutW-1:0] out_len_q, out_len_d;
  logic                        out_last_q, out_last_d;

  logic             in_acc;
  logic             out_take;
  logic             consume;
  logic [ByteW-1:0] sum_add;
  logic [IdxW-1:0]  ndata;
  logic             ram_we, ram_re;
  logic [ByteW-1:0] ram_rdata;

  // Handshake terms
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign consume  = pend_q && (!out_valid_q || out_take);

  // Shared checksum adder
  assign sum_add = sum_q + rx_byte_i;

  // Data words in the frame; the length check keeps this below the buffer depth + 1
  assign ndata = len_q[IdxW-1:0] - IdxW'(1);

  // Configuration registers: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= asfr_pkg::HeaderReset;
      node_q   <= asfr_pkg::NodeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        asfr_pkg::CfgHeaderValue: header_q <= cfg_data_i;
        asfr_pkg::CfgNodeAddress: node_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Data buffer
  asfr_ram #(
    .Width (ByteW),
    .Depth (MaxDataBytes)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer: next state and outputs
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    len_d       = len_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q && !out_take;
    out_cmd_d   = out_cmd_q;
    out_val_d   = out_val_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    in_stall_o  = 1'b0;

    case (state_q)
      asfr_pkg::ST_HEADER: begin
        if (in_acc && rx_byte_i == header_q) begin
          sum_d   = '0;
          idx_d   = '0;
          state_d = asfr_pkg::ST_ADDRESS;
        end
      end

      asfr_pkg::ST_ADDRESS: begin
        if (in_acc) begin
          if (rx_byte_i == asfr_pkg::BroadcastAddr || rx_byte_i == node_q) begin
            sum_d   = rx_byte_i;
            state_d = asfr_pkg::ST_LENGTH;
          end else begin
            state_d = asfr_pkg::ST_HEADER;
          end
        end
      end

      asfr_pkg::ST_LENGTH: begin
        if (in_acc) begin
          len_d = rx_byte_i;
          if (rx_byte_i == '0 || {1'b0, rx_byte_i} > MaxLen) begin
            state_d = asfr_pkg::ST_HEADER;
          end else begin
            sum_d   = sum_add;
            state_d = asfr_pkg::ST_COMMAND;
          end
        end
      end

      asfr_pkg::ST_COMMAND: begin
        if (in_acc) begin
          cmd_d   = rx_byte_i;
          idx_d   = '0;
          sum_d   = sum_add;
          state_d = (len_q == ByteW'(1)) ? asfr_pkg::ST_CHECKSUM : asfr_pkg::ST_DATA;
        end
      end

      asfr_pkg::ST_DATA: begin
        if (in_acc) begin
          ram_we = ({1'b0, idx_q} < MaxIdx);
          idx_d  = idx_q + IdxW'(1);
          sum_d  = sum_add;
          if ((ByteW + 1)'(idx_d) + (ByteW + 1)'(1) >= {1'b0, len_q}) begin
            state_d = asfr_pkg::ST_CHECKSUM;
          end
        end
      end

      asfr_pkg::ST_CHECKSUM: begin
        // Hold the checksum word until the output register has room
        in_stall_o = out_valid_q && out_stall_i;
        if (in_acc) begin
          state_d = asfr_pkg::ST_HEADER;
          if (sum_q == rx_byte_i) begin
            out_valid_d = 1'b1;
            out_cmd_d   = 1'b1;
            out_val_d   = cmd_q;
            out_len_d   = len_q[asfr_pkg::LenOutW-1:0];
            out_last_d  = (ndata == '0);
            if (ndata != '0) begin
              rd_idx_d = '0;
              pend_d   = 1'b0;
              state_d  = asfr_pkg::ST_EMIT;
            end
          end
        end
      end

      asfr_pkg::ST_EMIT: begin
        in_stall_o = 1'b1;
        // Move the fetched data word into the output register
        if (consume) begin
          out_valid_d = 1'b1;
          out_cmd_d   = 1'b0;
          out_val_d   = ram_rdata;
          out_last_d  = pend_last_q;
          pend_d      = 1'b0;
        end
        // Fetch the next data word once the read data slot is free
        if (rd_idx_q != ndata && (!pend_q || consume)) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = (rd_idx_q + IdxW'(1) == ndata);
          rd_idx_d    = rd_idx_q + IdxW'(1);
        end
        if (rd_idx_q == ndata && !pend_q) begin
          state_d = asfr_pkg::ST_HEADER;
        end
      end

      default: begin
        state_d = asfr_pkg::ST_HEADER;
      end
    endcase
  end

  // Sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asfr_pkg::ST_HEADER;
      sum_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      cmd_q       <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      cmd_q       <= cmd_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    out_cmd_q  <= out_cmd_d;
    out_val_q  <= out_val_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign is_command_o   = out_cmd_q;
  assign value_o        = out_val_q;
  assign frame_length_o = out_len_q;
  assign last_o         = out_last_q;

  // A fetched word is only outstanding while the burst is being sent
  `ASSERT_AT(a_pend_in_emit, pend_q |-> state_q == asfr_pkg::ST_EMIT)
  // The read pointer never passes the data count of the frame
  `ASSERT_AT(a_rd_idx_bound, state_q == asfr_pkg::ST_EMIT |-> rd_idx_q <= ndata)
  // Buffer writes and reads never share a cycle
  `ASSERT_NEVER(a_ram_we_re, ram_we && ram_re)
  // A fetch always leaves its word pending in the read data slot
  `ASSERT_AT(a_fetch_slot, ram_re |=> pend_q)

endmodule

`default_nettype wire
